// File: rtl/bsdp_pkg.sv
// Shared types, constants and helpers for the button single / double press detector.
// Depends on nothing; every other file in the project imports this package.
package bsdp_pkg;

   // Width of timestamps and time limits.
   localparam int TIME_BITS = 32;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESSED_LEVEL       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASED_LEVEL      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_TIME           = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_PRESS_WINDOW = 2'd3;
   localparam int CSR_DATA_BITS = TIME_BITS;

   // Reset values of the configuration registers.
   localparam logic                 RST_PRESSED_LEVEL       = 1'b1;
   localparam logic                 RST_RELEASED_LEVEL      = 1'b0;
   localparam logic [TIME_BITS-1:0] RST_HOLD_TIME           = TIME_BITS'(50);
   localparam logic [TIME_BITS-1:0] RST_SECOND_PRESS_WINDOW = TIME_BITS'(300);

   // Phases of the press machine.
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_FIRST     = 3'd1,
      PH_FIRST_OK  = 3'd2,
      PH_RELEASED  = 3'd3,
      PH_SECOND    = 3'd4,
      PH_SECOND_OK = 3'd5
   } phase_type;

   // One poll beat on the request channel.
   typedef struct packed {
      logic [TIME_BITS-1:0] now_ticks;
      logic                 button_level;
   } req_type;

   // One result beat on the response channel.
   typedef struct packed {
      logic single_press;
      logic double_press;
   } rsp_type;

   // Configuration as seen by the press machine.
   typedef struct packed {
      logic                 pressed_level;
      logic                 released_level;
      logic [TIME_BITS-1:0] hold_time;
      logic [TIME_BITS-1:0] second_press_window;
   } cfg_type;

   // Machine state handed between the state registers and the next-state logic.
   typedef struct packed {
      phase_type            phase;
      logic [TIME_BITS-1:0] press_start;
      logic [TIME_BITS-1:0] release_start;
   } mach_type;

   // A limit of zero always counts as passed; a zero timestamp means no time is
   // known. Otherwise the wrapped elapsed time must strictly exceed the limit.
   function automatic logic limit_passed(input logic [TIME_BITS-1:0] now,
                                         input logic [TIME_BITS-1:0] start,
                                         input logic [TIME_BITS-1:0] limit);
      logic [TIME_BITS-1:0] elapsed;
      elapsed = now - start;
      if (limit == '0) begin
         return 1'b1;
      end else if (now == '0) begin
         return 1'b0;
      end else begin
         return elapsed > limit;
      end
   endfunction

endpackage

// File: rtl/bsdp_cfg_regs.sv
// Configuration registers of the press detector, written through a plain write port.
// Depends on bsdp_pkg for the register indexes, reset values and cfg_type.
module bsdp_cfg_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bsdp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bsdp_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output bsdp_pkg::cfg_type                     cfg
);
   import bsdp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESSED_LEVEL:       cfg_in.pressed_level       = csr_wdata[0];
            CSR_RELEASED_LEVEL:      cfg_in.released_level      = csr_wdata[0];
            CSR_HOLD_TIME:           cfg_in.hold_time           = csr_wdata[TIME_BITS-1:0];
            CSR_SECOND_PRESS_WINDOW: cfg_in.second_press_window = csr_wdata[TIME_BITS-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Registers, loaded with their documented values at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressed_level       <= RST_PRESSED_LEVEL;
         cfg_ff.released_level      <= RST_RELEASED_LEVEL;
         cfg_ff.hold_time           <= RST_HOLD_TIME;
         cfg_ff.second_press_window <= RST_SECOND_PRESS_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/bsdp_phase_logic.sv
// Next-state logic of the press machine for one poll, with its chained transitions.
// Depends on bsdp_pkg for phase_type, mach_type, cfg_type and limit_passed.
module bsdp_phase_logic (
   input  bsdp_pkg::req_type    poll,
   input  bsdp_pkg::cfg_type    cfg,
   input  bsdp_pkg::mach_type   cur,
   output bsdp_pkg::mach_type   nxt,
   output bsdp_pkg::rsp_type    result
);
   import bsdp_pkg::*;

   logic hold_old;
   logic hold_fresh;
   logic window_old;
   logic window_fresh;
   logic is_pressed;
   logic is_released;

   // Time checks against the stored start times, and against a start taken in
   // this very poll, where the elapsed time is zero.
   assign hold_old     = limit_passed(poll.now_ticks, cur.press_start, cfg.hold_time);
   assign window_old   = limit_passed(poll.now_ticks, cur.release_start,
                                      cfg.second_press_window);
   assign hold_fresh   = (cfg.hold_time == '0);
   assign window_fresh = (cfg.second_press_window == '0);

   // When both levels are the same, a matching level counts as pressed only.
   assign is_pressed  = (poll.button_level == cfg.pressed_level);
   assign is_released = !is_pressed && (poll.button_level == cfg.released_level);

   // Transitions; a poll may chain several of them in a fixed order.
   always_comb begin
      nxt    = cur;
      result = '0;
      if (is_pressed) begin
         case (cur.phase)
            PH_FIRST: begin
               if (hold_old) nxt.phase = PH_FIRST_OK;
            end
            PH_FIRST_OK, PH_SECOND_OK: begin
               nxt.phase = cur.phase;
            end
            PH_RELEASED: begin
               // A press after the window has expired leaves the phase alone.
               if (!window_old) begin
                  nxt.press_start = poll.now_ticks;
                  nxt.phase       = hold_fresh ? PH_SECOND_OK : PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (hold_old) nxt.phase = PH_SECOND_OK;
            end
            default: begin
               // Idle, and any unused code, starts a first press.
               nxt.press_start = poll.now_ticks;
               nxt.phase       = hold_fresh ? PH_FIRST_OK : PH_FIRST;
            end
         endcase
      end else if (is_released) begin
         case (cur.phase)
            PH_FIRST_OK: begin
               nxt.release_start = poll.now_ticks;
               if (window_fresh) begin
                  nxt.phase           = PH_IDLE;
                  result.single_press = 1'b1;
               end else begin
                  nxt.phase = PH_RELEASED;
               end
            end
            PH_RELEASED: begin
               if (window_old) begin
                  nxt.phase           = PH_IDLE;
                  result.single_press = 1'b1;
               end
            end
            PH_SECOND_OK: begin
               nxt.phase           = PH_IDLE;
               result.double_press = 1'b1;
            end
            default: begin
               // A press released too early, or idle, goes back to idle.
               nxt.phase = PH_IDLE;
            end
         endcase
      end else begin
         // A level that matches neither setting leaves the phase as it is,
         // but an unused code is still read as idle.
         case (cur.phase)
            PH_IDLE, PH_FIRST, PH_FIRST_OK, PH_RELEASED, PH_SECOND, PH_SECOND_OK: begin
               nxt.phase = cur.phase;
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

// File: rtl/button_single_double_press_detector.sv
// Button single / double press detector: each request beat is one poll of the
// button with a timestamp, and each poll gives exactly one response beat.
//
// Channels: req_ carries a poll (now_ticks, button_level) and rsp_ carries the
// result flags (single_press, double_press); a beat moves at a rising edge at
// which valid is high and stall is low. The csr_ port writes one of four
// registers per cycle and should be used only while no poll is in flight.
// Path: an accepted poll is registered in the input stage, runs through the
// press machine and is registered in the result register, which drives rsp_.
// Throughput: one poll per cycle while the receiver does not stall; the press
// machine with its two elapsed-time compares sits between the input register
// and the result register. When the receiver stalls, the result holds in the
// result register and the input stage still takes one more poll; further polls
// are stalled until the result is taken.
// Reset (synchronous, active high) empties both stages, returns the machine
// to idle with zero start times and restores the register defaults.
// Depends on bsdp_pkg, bsdp_cfg_regs and bsdp_phase_logic.
module button_single_double_press_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bsdp_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bsdp_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [bsdp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bsdp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import bsdp_pkg::*;

   cfg_type  cfg;
   mach_type mach_ff;
   mach_type mach_nxt;
   rsp_type  result;

   req_type  poll_ff;
   logic     poll_valid_ff;
   logic     poll_valid_in;
   rsp_type  rsp_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   logic     req_take;
   logic     advance;

   bsdp_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bsdp_phase_logic u_phase (
      .poll   (poll_ff),
      .cfg    (cfg),
      .cur    (mach_ff),
      .nxt    (mach_nxt),
      .result (result)
   );

   // The held poll moves on when the result register is empty or being emptied.
   assign advance   = poll_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = poll_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   assign poll_valid_in = req_take || (poll_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Input register takes a beat whenever one is accepted.
   always_ff @(posedge clock) begin
      if (req_take) begin
         poll_ff <= req_data;
      end
   end

   // Press machine state and result register update as a poll moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         mach_ff.phase         <= PH_IDLE;
         mach_ff.press_start   <= '0;
         mach_ff.release_start <= '0;
      end else if (advance) begin
         mach_ff <= mach_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for button_single_double_press_detector: polls with
// random idling on both channels, checked beat by beat against a press predictor.
// Depends on bsdp_pkg and the detector RTL only.
`timescale 1ns / 100ps

module testbench;
   import bsdp_pkg::*;

   localparam int DIRECTED_COUNT = 30;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_POLLS    = 112;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTED   = 10;

   typedef enum logic {ROW_POLL, ROW_SETUP} row_kind_type;

   // One row of the directed table: either a poll beat or a full register setting.
   typedef struct {
      row_kind_type kind;
      logic         typed;
      req_type      beat;
      rsp_type      flags;
      cfg_type      setting;
   } stimulus_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Predictor state and the flags still owed by the block.
   cfg_type              active_cfg;
   phase_type            button_phase;
   logic [TIME_BITS-1:0] press_start;
   logic [TIME_BITS-1:0] release_start;
   rsp_type              pending_flags[$];

   int          fault_count = 0;
   int unsigned quiet_cycles = 0;
   int          stall_run = 0;
   logic        sender_gaps_on = 1'b1;
   logic        receiver_stalls_on = 1'b1;

   stimulus_row_type directed_rows [DIRECTED_COUNT];

   button_single_double_press_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A zero limit has always passed; a zero timestamp never passes a real limit.
   function automatic logic span_exceeded(input logic [TIME_BITS-1:0] now,
                                          input logic [TIME_BITS-1:0] start,
                                          input logic [TIME_BITS-1:0] limit);
      return (limit == '0) || (now != '0 && TIME_BITS'(now - start) > limit);
   endfunction

   // Advances the press machine by one poll and returns the flags it raises.
   // The transitions are tried in a fixed order, so several may chain.
   function automatic rsp_type press_machine_step(input req_type beat);
      rsp_type flags;
      flags = '0;
      if (beat.button_level == active_cfg.pressed_level) begin
         if (button_phase == PH_IDLE) begin
            button_phase = PH_FIRST;
            press_start = beat.now_ticks;
         end
         if (button_phase == PH_FIRST &&
             span_exceeded(beat.now_ticks, press_start, active_cfg.hold_time)) begin
            button_phase = PH_FIRST_OK;
         end
         if (button_phase == PH_RELEASED &&
             !span_exceeded(beat.now_ticks, release_start,
                            active_cfg.second_press_window)) begin
            button_phase = PH_SECOND;
            press_start = beat.now_ticks;
         end
         if (button_phase == PH_SECOND &&
             span_exceeded(beat.now_ticks, press_start, active_cfg.hold_time)) begin
            button_phase = PH_SECOND_OK;
         end
      end else if (beat.button_level == active_cfg.released_level) begin
         if (button_phase == PH_FIRST_OK) begin
            button_phase = PH_RELEASED;
            release_start = beat.now_ticks;
         end
         if (button_phase == PH_RELEASED &&
             span_exceeded(beat.now_ticks, release_start,
                           active_cfg.second_press_window)) begin
            flags.single_press = 1'b1;
            button_phase = PH_IDLE;
         end
         if (button_phase == PH_SECOND_OK) begin
            flags.double_press = 1'b1;
            button_phase = PH_IDLE;
         end
         if (button_phase == PH_FIRST || button_phase == PH_SECOND) begin
            button_phase = PH_IDLE;
         end
      end
      return flags;
   endfunction

   function automatic stimulus_row_type poll_row(input logic [TIME_BITS-1:0] now,
                                                 input logic level);
      stimulus_row_type row;
      row.kind = ROW_POLL;
      row.typed = 1'b0;
      row.beat.now_ticks = now;
      row.beat.button_level = level;
      row.flags = '0;
      row.setting = '0;
      return row;
   endfunction

   function automatic stimulus_row_type checked_row(input logic [TIME_BITS-1:0] now,
                                                    input logic level,
                                                    input logic single,
                                                    input logic dbl);
      stimulus_row_type row;
      row = poll_row(now, level);
      row.typed = 1'b1;
      row.flags.single_press = single;
      row.flags.double_press = dbl;
      return row;
   endfunction

   function automatic stimulus_row_type setup_row(input logic pressed,
                                                  input logic released,
                                                  input logic [TIME_BITS-1:0] hold,
                                                  input logic [TIME_BITS-1:0] window);
      stimulus_row_type row;
      row = poll_row('0, 1'b0);
      row.kind = ROW_SETUP;
      row.setting.pressed_level = pressed;
      row.setting.released_level = released;
      row.setting.hold_time = hold;
      row.setting.second_press_window = window;
      return row;
   endfunction

   task automatic note_fault(input string what, input rsp_type wanted, input rsp_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTED) begin
         $display("%0t: %s: expected single=%0b double=%0b, got single=%0b double=%0b",
                  $time, what, wanted.single_press, wanted.double_press,
                  got.single_press, got.double_press);
      end
   endtask

   // Waits for the block to go idle, then writes all four registers, one per cycle.
   // The upper data bits of the level registers carry noise.
   task automatic apply_setting(input cfg_type setting);
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_PRESSED_LEVEL;
      csr_wdata <= {(CSR_DATA_BITS-1)'($urandom), setting.pressed_level};
      @(posedge clock);
      csr_index <= CSR_RELEASED_LEVEL;
      csr_wdata <= {(CSR_DATA_BITS-1)'($urandom), setting.released_level};
      @(posedge clock);
      csr_index <= CSR_HOLD_TIME;
      csr_wdata <= setting.hold_time;
      @(posedge clock);
      csr_index <= CSR_SECOND_PRESS_WINDOW;
      csr_wdata <= setting.second_press_window;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_cfg = setting;
   endtask

   // Presents one poll beat and holds it until accepted. Valid is left high so
   // that a following beat can go out back to back.
   task automatic send_poll(input req_type beat, input logic typed, input rsp_type flags);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = press_machine_step(beat);
      pending_flags.push_back(typed ? flags : predicted);
   endtask

   // Idles the sender after a beat: mostly not at all, sometimes briefly, rarely long.
   // With drain set it waits until every owed result has arrived.
   task automatic sender_pause(input logic drain);
      int gap;
      int roll;
      gap = 0;
      roll = $urandom_range(0, 19);
      if (sender_gaps_on) begin
         if (roll >= 18) begin
            gap = $urandom_range(8, 30);
         end else if (roll >= 11) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (drain) begin
         req_valid <= 1'b0;
         while (pending_flags.size() != 0) @(posedge clock);
      end else if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver stalls in runs: mostly short ones, a few long ones.
   always @(posedge clock) begin
      if (reset || !receiver_stalls_on) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
         end
      end
   end

   // Each result beat is matched against the oldest owed flags.
   always @(posedge clock) begin
      rsp_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_flags.size() == 0) begin
            note_fault("result beat with nothing owed", '0, rsp_data);
         end else begin
            wanted = pending_flags.pop_front();
            if (rsp_data.single_press !== wanted.single_press ||
                rsp_data.double_press !== wanted.double_press) begin
               note_fault("result beat differs", wanted, rsp_data);
            end
         end
      end
   end

   // The run ends if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      cfg_type              setting;
      req_type              beat;
      logic [TIME_BITS-1:0] tick;
      logic                 pressing;
      logic                 level;
      int                   run_left;
      int                   roll;
      int unsigned          step_max;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_PRESSED_LEVEL;
      csr_wdata = '0;

      active_cfg.pressed_level = RST_PRESSED_LEVEL;
      active_cfg.released_level = RST_RELEASED_LEVEL;
      active_cfg.hold_time = RST_HOLD_TIME;
      active_cfg.second_press_window = RST_SECOND_PRESS_WINDOW;
      button_phase = PH_IDLE;
      press_start = '0;
      release_start = '0;

      directed_rows = '{
         // Reset settings: single press, double press, short press.
         poll_row(32'd200, 1'b1),
         poll_row(32'd260, 1'b1),
         poll_row(32'd270, 1'b0),
         checked_row(32'd600, 1'b0, 1'b1, 1'b0),
         poll_row(32'd1000, 1'b1),
         poll_row(32'd1100, 1'b1),
         poll_row(32'd1110, 1'b0),
         poll_row(32'd1200, 1'b1),
         poll_row(32'd1300, 1'b1),
         checked_row(32'd1310, 1'b0, 1'b0, 1'b1),
         poll_row(32'd2000, 1'b1),
         checked_row(32'd2010, 1'b0, 1'b0, 1'b0),
         // Press across the wrap, a zero timestamp, then a second press too late.
         poll_row(32'hFFFF_FFF0, 1'b1),
         poll_row(32'h0000_0000, 1'b1),
         poll_row(32'h0000_0030, 1'b1),
         poll_row(32'h0000_0040, 1'b0),
         poll_row(32'h0000_01D0, 1'b1),
         checked_row(32'h0000_01E0, 1'b0, 1'b1, 1'b0),
         // Zero hold and widest window: each press qualifies within its own poll.
         setup_row(1'b1, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF),
         poll_row(32'd5, 1'b1),
         poll_row(32'd6, 1'b0),
         poll_row(32'd7, 1'b1),
         checked_row(32'd8, 1'b0, 1'b0, 1'b1),
         // Inverted levels and zero window: the release itself reports the single press.
         setup_row(1'b0, 1'b1, 32'd10, 32'h0000_0000),
         poll_row(32'd20, 1'b0),
         poll_row(32'd31, 1'b0),
         checked_row(32'd32, 1'b1, 1'b1, 1'b0),
         // Equal levels: the other level matches neither and changes nothing.
         setup_row(1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000),
         poll_row(32'd40, 1'b1),
         checked_row(32'd41, 1'b0, 1'b0, 1'b0)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_SETUP) begin
            apply_setting(directed_rows[i].setting);
         end else begin
            send_poll(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].flags);
            sender_pause(1'b0);
         end
      end

      // Random phases, each under its own register setting and idling mix.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         level = 1'($urandom);
         case (p)
            0: begin
               setting.pressed_level = RST_PRESSED_LEVEL;
               setting.released_level = RST_RELEASED_LEVEL;
               setting.hold_time = RST_HOLD_TIME;
               setting.second_press_window = RST_SECOND_PRESS_WINDOW;
            end
            1: begin
               setting.pressed_level = 1'b1;
               setting.released_level = 1'b0;
               setting.hold_time = '0;
               setting.second_press_window = '0;
            end
            2: begin
               setting.pressed_level = 1'b0;
               setting.released_level = 1'b1;
               setting.hold_time = '1;
               setting.second_press_window = '1;
            end
            3: begin
               setting.pressed_level = level;
               setting.released_level = level;
               setting.hold_time = $urandom_range(1, 40);
               setting.second_press_window = $urandom_range(1, 150);
            end
            default: begin
               setting.pressed_level = level;
               setting.released_level = ($urandom_range(0, 5) == 0) ? level : ~level;
               setting.hold_time = ($urandom_range(0, 9) == 0) ? $urandom
                                                               : $urandom_range(0, 60);
               setting.second_press_window = ($urandom_range(0, 9) == 0) ?
                                             $urandom : $urandom_range(0, 200);
            end
         endcase
         apply_setting(setting);
         sender_gaps_on = (p % 3 != 1);
         receiver_stalls_on = (p % 4 != 2);

         step_max = ((setting.hold_time > 3000) ? 3000 : setting.hold_time) / 6 +
                    ((setting.second_press_window > 3000) ? 3000
                                                          : setting.second_press_window) / 6 + 2;
         tick = (p % 2 == 1) ? 32'hFFFF_FE00 : $urandom;
         pressing = 1'b0;
         run_left = 0;

         // Mostly press and release runs with advancing time; the rest is noise,
         // time jumps and zero timestamps.
         for (int n = 0; n < PHASE_POLLS; n++) begin
            if (run_left == 0) begin
               pressing = ~pressing;
               run_left = pressing ? $urandom_range(1, 6) : $urandom_range(1, 10);
            end
            run_left--;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               beat.now_ticks = $urandom;
               beat.button_level = 1'($urandom);
            end else begin
               if (roll < 12) begin
                  tick = $urandom;
               end else begin
                  tick = tick + $urandom_range(0, step_max);
               end
               beat.now_ticks = (roll < 15) ? '0 : tick;
               beat.button_level = pressing ? setting.pressed_level : setting.released_level;
            end
            send_poll(beat, 1'b0, '0);
            sender_pause(n == PHASE_POLLS / 2 || $urandom_range(0, 49) == 0);
         end
      end

      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (fault_count == 0 && pending_flags.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
